// ===== src/ppw_pkg.sv =====
package ppw_pkg;

	localparam int MAX_SEGS_DEF = 256;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	localparam logic [1:0] KIND_MOVE  = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [1:0]         vert_kind;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic [1:0]         kind;
		logic [31:0]        len;
	} seg_t;

endpackage

// ===== src/polyline_point_warp.sv =====
// Polyline point warp. Vertices (move, line, close) are appended one beat at a
// time and stored with their segment length; a query beat maps (point_x,
// point_y) onto the stored path. Drive start while busy is low; the beat is
// taken on that edge. A result appears on result for exactly one cycle with
// done high and cannot be held off, so capture it when done is seen. Clear
// and successful appends give no result. A move append is stored as the beat
// is taken; a line or close append squares the two differences on the shared
// multiplier and takes a 33-step square root. A query walks the segment memory
// one segment at a time, each a read then a check, then forms four products,
// each divided by the segment length one quotient bit a cycle, and registers
// the result in a final state.
module polyline_point_warp #(
	parameter int MAX_SEGS = ppw_pkg::MAX_SEGS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ppw_pkg::item_t   item,
	output logic             done,
	output ppw_pkg::result_t result
);
	import ppw_pkg::*;

	localparam int IDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
	localparam int CNT_W = $clog2(MAX_SEGS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WRD  = 4'd1;
	localparam logic [3:0] S_WCHK = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_DLD  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_SQA  = 4'd7;
	localparam logic [3:0] S_SQB  = 4'd8;
	localparam logic [3:0] S_SQC  = 4'd9;
	localparam logic [3:0] S_SQRT = 4'd10;

	logic [3:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       idx_q;
	logic signed [31:0]     cur_x_q, cur_y_q, mov_x_q, mov_y_q;
	logic signed [31:0]     tgt_x_q, tgt_y_q;
	logic [1:0]             kind_q;
	logic signed [32:0]     x_q, dx_q, dy_q;
	logic signed [31:0]     cx_q, cy_q, px_q, py_q;
	logic [31:0]            len_q;
	logic signed [65:0]     prod_q;
	logic [65:0]            acc_q;
	logic [1:0]             k_q;
	logic                   dsign_q;
	logic [65:0]            dvd_q;
	logic [32:0]            rem_q;
	logic [6:0]             cnt_q;
	logic [33:0]            srem_q;
	logic [32:0]            root_q;
	logic signed [41:0]     quo_q [4];
	logic                   done_q;
	result_t                result_q;

	seg_t                   mem [MAX_SEGS];
	seg_t                   rdata_q;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	seg_t                   wdata;

	logic                   accept;
	logic signed [32:0]     mul_a, mul_b;
	logic [32:0]            rem_sh;
	logic                   qbit;
	logic [35:0]            srem_sh, trial;
	logic [40:0]            qmag;
	logic                   pass;
	logic [CNT_W-1:0]       nxt;
	logic signed [43:0]     rx, ry;

	function automatic logic [31:0] sat32(input logic signed [43:0] v);
		if (v > 44'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (v < -44'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// segment memory: one write port, registered read at the walk index
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[idx_q];
	end

	// shared multiplier operands
	always_comb begin
		mul_a = dx_q;
		mul_b = dx_q;
		case (state_q)
			S_SQA: begin mul_a = dx_q; mul_b = dx_q; end
			S_SQB: begin mul_a = dy_q; mul_b = dy_q; end
			S_MUL: begin
				case (k_q)
					2'd0:    begin mul_a = dx_q; mul_b = x_q; end
					2'd1:    begin mul_a = dy_q; mul_b = 33'(py_q); end
					2'd2:    begin mul_a = dy_q; mul_b = x_q; end
					default: begin mul_a = dx_q; mul_b = 33'(py_q); end
				endcase
			end
			default: begin mul_a = dx_q; mul_b = dx_q; end
		endcase
	end

	// divider and root steps, walk test, final sums
	always_comb begin
		rem_sh  = {rem_q[31:0], dvd_q[65]};
		qbit    = rem_sh >= {1'b0, len_q};
		srem_sh = {srem_q, acc_q[65:64]};
		trial   = {1'b0, root_q, 2'b01};
		qmag    = (dvd_q > 66'(41'h100_0000_0000)) ? 41'h100_0000_0000 : dvd_q[40:0];
		nxt     = CNT_W'(idx_q) + CNT_W'(1);
		pass    = (nxt < count_q) &&
		          ((x_q > $signed({1'b0, rdata_q.len})) || (rdata_q.kind == KIND_MOVE));
		rx      = 44'(cx_q) + 44'(quo_q[0]) - 44'(quo_q[1]);
		ry      = 44'(cy_q) + 44'(quo_q[2]) + 44'(quo_q[3]);
	end

	// memory write for a move append or a finished length
	always_comb begin
		we          = 1'b0;
		waddr       = count_q[IDX_W-1:0];
		wdata.end_x = tgt_x_q;
		wdata.end_y = tgt_y_q;
		wdata.kind  = kind_q;
		wdata.len   = root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];
		if (state_q == S_IDLE && accept && item.req_type == REQ_APPEND &&
		    item.vert_kind == KIND_MOVE && count_q < CNT_W'(MAX_SEGS)) begin
			we          = 1'b1;
			wdata.end_x = item.vert_x;
			wdata.end_y = item.vert_y;
			wdata.kind  = KIND_MOVE;
			wdata.len   = '0;
		end else if (state_q == S_SQRT && cnt_q == '0) begin
			we = 1'b1;
		end
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			mov_x_q <= '0;
			mov_y_q <= '0;
			done_q  <= 1'b0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						px_q <= item.point_x;
						py_q <= item.point_y;
						case (item.req_type)
							REQ_CLEAR: begin
								count_q <= '0;
								cur_x_q <= '0;
								cur_y_q <= '0;
								mov_x_q <= '0;
								mov_y_q <= '0;
							end
							REQ_APPEND: begin
								if (item.vert_kind != KIND_NONE) begin
									if (count_q >= CNT_W'(MAX_SEGS)) begin
										result_q <= '{out_x: '0, out_y: '0, status: ST_EMPTY};
										done_q   <= 1'b1;
									end else if (item.vert_kind == KIND_MOVE) begin
										mov_x_q <= item.vert_x;
										mov_y_q <= item.vert_y;
										cur_x_q <= item.vert_x;
										cur_y_q <= item.vert_y;
										count_q <= count_q + CNT_W'(1);
									end else begin
										kind_q <= item.vert_kind;
										if (item.vert_kind == KIND_CLOSE) begin
											tgt_x_q <= mov_x_q;
											tgt_y_q <= mov_y_q;
											dx_q <= 33'(mov_x_q) - 33'(cur_x_q);
											dy_q <= 33'(mov_y_q) - 33'(cur_y_q);
										end else begin
											tgt_x_q <= item.vert_x;
											tgt_y_q <= item.vert_y;
											dx_q <= 33'(item.vert_x) - 33'(cur_x_q);
											dy_q <= 33'(item.vert_y) - 33'(cur_y_q);
										end
										state_q <= S_SQA;
									end
								end
							end
							REQ_QUERY: begin
								if (count_q == '0) begin
									result_q <= '{out_x: item.point_x, out_y: item.point_y,
									              status: ST_EMPTY};
									done_q   <= 1'b1;
								end else begin
									idx_q   <= '0;
									x_q     <= 33'(item.point_x);
									cx_q    <= '0;
									cy_q    <= '0;
									state_q <= S_WRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				// wait for the registered read
				S_WRD: state_q <= S_WCHK;
				// pass the segment or land on it
				S_WCHK: begin
					if (pass) begin
						x_q     <= x_q - $signed({1'b0, rdata_q.len});
						cx_q    <= rdata_q.end_x;
						cy_q    <= rdata_q.end_y;
						idx_q   <= nxt[IDX_W-1:0];
						state_q <= S_WRD;
					end else if (rdata_q.kind == KIND_MOVE || rdata_q.len == '0) begin
						result_q <= '{out_x: px_q, out_y: py_q,
						              status: (rdata_q.kind == KIND_MOVE) ? ST_OK : ST_ZERO};
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						len_q   <= rdata_q.len;
						dx_q    <= 33'(rdata_q.end_x) - 33'(cx_q);
						dy_q    <= 33'(rdata_q.end_y) - 33'(cy_q);
						k_q     <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_DLD;
				end
				// load divider with the product magnitude
				S_DLD: begin
					dsign_q <= prod_q[65];
					dvd_q   <= prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
					rem_q   <= '0;
					cnt_q   <= 7'd66;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q != '0) begin
						rem_q <= qbit ? rem_sh - {1'b0, len_q} : rem_sh;
						dvd_q <= {dvd_q[64:0], qbit};
						cnt_q <= cnt_q - 7'd1;
					end else begin
						quo_q[k_q] <= dsign_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
						k_q        <= k_q + 2'd1;
						state_q    <= (k_q == 2'd3) ? S_FIN : S_MUL;
					end
				end
				S_FIN: begin
					result_q <= '{out_x: sat32(rx), out_y: sat32(ry), status: ST_OK};
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				// square the differences and sum
				S_SQA: begin
					prod_q  <= mul_a * mul_b;
					state_q <= S_SQB;
				end
				S_SQB: begin
					acc_q   <= prod_q[65:0];
					prod_q  <= mul_a * mul_b;
					state_q <= S_SQC;
				end
				S_SQC: begin
					acc_q   <= acc_q + prod_q[65:0];
					srem_q  <= '0;
					root_q  <= '0;
					cnt_q   <= 7'd33;
					state_q <= S_SQRT;
				end
				// one root bit a cycle, then store the segment
				S_SQRT: begin
					if (cnt_q != '0) begin
						if (srem_sh >= trial) begin
							srem_q <= 34'(srem_sh - trial);
							root_q <= {root_q[31:0], 1'b1};
						end else begin
							srem_q <= srem_sh[33:0];
							root_q <= {root_q[31:0], 1'b0};
						end
						acc_q <= {acc_q[63:0], 2'b00};
						cnt_q <= cnt_q - 7'd1;
					end else begin
						cur_x_q <= tgt_x_q;
						cur_y_q <= tgt_y_q;
						count_q <= count_q + CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/ppw_checker.sv =====
module ppw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input ppw_pkg::item_t   item,
	input logic             done,
	input ppw_pkg::result_t result
);
	import ppw_pkg::*;

	// clear leaves the block idle and silent
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.req_type == REQ_CLEAR) |=> (!busy && !done))
		else $error("clear beat produced work or a result");

	// a query either answers at once or starts working
	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.req_type == REQ_QUERY) |=> (busy || done))
		else $error("query beat dropped");

	// unused vertex kind is ignored
	a_nokind: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.req_type == REQ_APPEND && item.vert_kind == KIND_NONE)
		|=> (!busy && !done))
		else $error("unused vertex kind acted on");

	// zero-length status only comes out of a segment walk
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_ZERO) |-> $past(busy))
		else $error("zero-length status without a walk");

endmodule

bind polyline_point_warp ppw_checker u_ppw_checker (.*);
